/* hw/rtl/mi3_pkg.sv */
package mi3_pkg;

  // Matrix shape.
  localparam int N_DIM  = 3;
  localparam int N_ELEM = N_DIM * N_DIM;

  // Integer bits of the input format; the rest of the word is fraction.
  localparam int INT_BITS = 4;

  // Per-element control that travels with the divider data.
  typedef struct packed {
    logic neg;   // quotient is negative
    logic zero;  // determinant is zero, force result to zero
  } mi3_ctl_t;

endpackage

/* hw/rtl/mi3_in_if.sv */
interface mi3_in_if #(
  parameter int IN_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] in_r0_c0;
  logic signed [IN_WIDTH-1:0] in_r0_c1;
  logic signed [IN_WIDTH-1:0] in_r0_c2;
  logic signed [IN_WIDTH-1:0] in_r1_c0;
  logic signed [IN_WIDTH-1:0] in_r1_c1;
  logic signed [IN_WIDTH-1:0] in_r1_c2;
  logic signed [IN_WIDTH-1:0] in_r2_c0;
  logic signed [IN_WIDTH-1:0] in_r2_c1;
  logic signed [IN_WIDTH-1:0] in_r2_c2;

  modport source (
    output valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1, in_r1_c2,
           in_r2_c0, in_r2_c1, in_r2_c2,
    input  ready
  );
  modport sink (
    input  valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1, in_r1_c2,
           in_r2_c0, in_r2_c1, in_r2_c2,
    output ready
  );
endinterface

/* hw/rtl/mi3_out_if.sv */
interface mi3_out_if #(
  parameter int OUT_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] out_r0_c0;
  logic signed [OUT_WIDTH-1:0] out_r0_c1;
  logic signed [OUT_WIDTH-1:0] out_r0_c2;
  logic signed [OUT_WIDTH-1:0] out_r1_c0;
  logic signed [OUT_WIDTH-1:0] out_r1_c1;
  logic signed [OUT_WIDTH-1:0] out_r1_c2;
  logic signed [OUT_WIDTH-1:0] out_r2_c0;
  logic signed [OUT_WIDTH-1:0] out_r2_c1;
  logic signed [OUT_WIDTH-1:0] out_r2_c2;
  logic                        singular;

  modport source (
    output valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1,
           out_r1_c2, out_r2_c0, out_r2_c1, out_r2_c2, singular,
    input  ready
  );
  modport sink (
    input  valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1,
           out_r1_c2, out_r2_c0, out_r2_c1, out_r2_c2, singular,
    output ready
  );
endinterface

/* hw/rtl/mi3_front.sv */
module mi3_front #(
  parameter int IN_WIDTH = 16,
  localparam int AW = 2 * IN_WIDTH + 1,
  localparam int DW = 3 * IN_WIDTH + 2
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [IN_WIDTH-1:0] m [mi3_pkg::N_ELEM],
  output logic        [AW-1:0]       adj_mag [mi3_pkg::N_ELEM],
  output logic        [DW-1:0]       det_mag,
  output mi3_pkg::mi3_ctl_t          ctl [mi3_pkg::N_ELEM]
);
  import mi3_pkg::*;

  localparam int PW = 2 * IN_WIDTH;
  localparam int TW = AW + IN_WIDTH;

  logic signed [PW-1:0]       p_r    [N_ELEM];
  logic signed [PW-1:0]       s_r    [N_ELEM];
  logic signed [IN_WIDTH-1:0] row1_r [N_DIM];
  logic signed [AW-1:0]       adj_r  [N_ELEM];
  logic signed [IN_WIDTH-1:0] row2_r [N_DIM];
  logic signed [AW-1:0]       adj3_r [N_ELEM];
  logic signed [TW-1:0]       dp_r   [N_DIM];
  logic signed [DW-1:0]       det;
  logic        [AW-1:0]       adj_mag_r [N_ELEM];
  logic        [DW-1:0]       det_mag_r;
  mi3_ctl_t                   ctl_r  [N_ELEM];

  // Stage 1: the two products of every 2x2 cofactor.
  for (genvar i = 0; i < N_DIM; i++) begin : g_row
    for (genvar j = 0; j < N_DIM; j++) begin : g_col
      localparam int I1 = (i + 1) % N_DIM;
      localparam int I2 = (i + 2) % N_DIM;
      localparam int J1 = (j + 1) % N_DIM;
      localparam int J2 = (j + 2) % N_DIM;
      always_ff @(posedge clk) begin
        if (en) begin
          p_r[i*N_DIM+j] <= m[J1*N_DIM+I1] * m[J2*N_DIM+I2];
          s_r[i*N_DIM+j] <= m[J1*N_DIM+I2] * m[J2*N_DIM+I1];
        end
      end
    end
  end

  // Stage 2: cofactor differences; stage 3: determinant partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_DIM; k++) begin
        row1_r[k] <= m[k];
        row2_r[k] <= row1_r[k];
        dp_r[k]   <= TW'(adj_r[k*N_DIM]) * TW'(row2_r[k]);
      end
      for (int e = 0; e < N_ELEM; e++) begin
        adj_r[e]  <= AW'(p_r[e]) - AW'(s_r[e]);
        adj3_r[e] <= adj_r[e];
      end
    end
  end

  // Stage 4: determinant, magnitudes and result signs.
  assign det = DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      det_mag_r <= det[DW-1] ? DW'(-det) : DW'(det);
      for (int e = 0; e < N_ELEM; e++) begin
        adj_mag_r[e]  <= adj3_r[e][AW-1] ? AW'(-adj3_r[e]) : AW'(adj3_r[e]);
        ctl_r[e].neg  <= adj3_r[e][AW-1] ^ det[DW-1];
        ctl_r[e].zero <= (det == '0);
      end
    end
  end

  assign adj_mag = adj_mag_r;
  assign det_mag = det_mag_r;
  assign ctl     = ctl_r;

endmodule

/* hw/rtl/mi3_lane.sv */
module mi3_lane #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32,
  localparam int AW = 2 * IN_WIDTH + 1,
  localparam int DW = 3 * IN_WIDTH + 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        num_mag,
  input  logic [DW-1:0]        den_mag,
  input  mi3_pkg::mi3_ctl_t    ctl_in,
  output logic [OUT_WIDTH-1:0] res,
  output mi3_pkg::mi3_ctl_t    ctl_out
);
  import mi3_pkg::*;

  localparam int SH = IN_WIDTH - INT_BITS + OUT_WIDTH / 2;
  localparam int NW = AW + SH;
  localparam int QB = OUT_WIDTH + 1;
  localparam int NX = NW + QB + 1;
  localparam int HW = NW + 1;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int QW = OUT_WIDTH + 2;

  logic [NX-1:0] n_ext;
  logic [HW-1:0] hi;
  logic          ovf;

  logic [DW-1:0] r_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [DW-1:0] d_r   [QB+1];
  logic          ovf_r [QB+1];
  mi3_ctl_t      ctl_r [QB+1];

  logic          rnd;
  logic [QW-1:0] qr;
  logic [QW-1:0] lim;
  logic [QW-1:0] mag;

  // Scaled numerator; quotients of QB bits or more saturate.
  assign n_ext = {{(QB + 1){1'b0}}, num_mag, {SH{1'b0}}};
  assign hi    = n_ext[NX-1:QB];
  assign ovf   = CW'(hi) >= CW'(den_mag);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= ovf ? '0 : DW'(hi);
      q_r[0]   <= '0;
      lo_r[0]  <= n_ext[QB-1:0];
      d_r[0]   <= den_mag;
      ovf_r[0] <= ovf;
      ctl_r[0] <= ctl_in;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [DW:0] t;
    logic        ge;
    assign t  = {r_r[k-1], lo_r[k-1][QB-1]};
    assign ge = t >= {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= ge ? DW'(t - {1'b0, d_r[k-1]}) : DW'(t);
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        lo_r[k]  <= lo_r[k-1] << 1;
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Round half away from zero on the magnitude, then saturate and sign.
  assign rnd = {r_r[QB], 1'b0} >= {1'b0, d_r[QB]};
  assign qr  = QW'(q_r[QB]) + QW'(rnd);
  assign lim = (QW'(1) << (OUT_WIDTH - 1)) - QW'(!ctl_r[QB].neg);
  assign mag = (ovf_r[QB] || (qr > lim)) ? lim : qr;

  always_comb begin
    if (ctl_r[QB].zero) begin
      res = '0;
    end else if (ctl_r[QB].neg) begin
      res = OUT_WIDTH'(QW'(0) - mag);
    end else begin
      res = OUT_WIDTH'(mag);
    end
  end

  assign ctl_out = ctl_r[QB];

endmodule

/* hw/rtl/matrix_inverse_3x3.sv */
// 3x3 matrix inverse by the adjugate, fixed point.
//
// in_ch carries one matrix per word: nine signed Q4.12 elements (row-major
// names in_rR_cC). out_ch returns the inverse as nine signed Q16.16 elements,
// rounded to nearest with ties away from zero and saturated, plus singular,
// which is set when the determinant is exactly zero; all elements are then 0.
// Both channels use valid/ready; a word moves when both are high.
//
// From input acceptance to output valid, four stages build the cofactors and
// the determinant, then nine parallel divider lanes spend one stage on the
// saturation check and OUT_WIDTH + 1 stages on quotient bits, one bit per
// stage, and the merge register presents the result. One matrix is accepted
// every cycle while the output register is free or its result is taken.
//
// The whole pipeline advances together; when the receiver holds off with a
// result waiting, every stage holds and in_ch.ready drops. Reset clears the
// valid bits of all stages and of the output register, and holds in_ch.ready low.
module matrix_inverse_3x3 #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  mi3_in_if.sink    in_ch,
  mi3_out_if.source out_ch
);
  import mi3_pkg::*;

  localparam int AW = 2 * IN_WIDTH + 1;
  localparam int DW = 3 * IN_WIDTH + 2;
  localparam int PL = 4 + OUT_WIDTH + 2;

  logic signed [IN_WIDTH-1:0]  m [N_ELEM];
  logic        [AW-1:0]        adj_mag [N_ELEM];
  logic        [DW-1:0]        det_mag;
  mi3_ctl_t                    ctl [N_ELEM];
  logic        [OUT_WIDTH-1:0] lane_res [N_ELEM];
  mi3_ctl_t                    lane_ctl [N_ELEM];

  logic                        en;
  logic        [PL-1:0]        vld_r;
  logic                        out_valid_r;
  logic        [OUT_WIDTH-1:0] res_r [N_ELEM];
  logic                        singular_r;

  assign m[0] = in_ch.in_r0_c0;
  assign m[1] = in_ch.in_r0_c1;
  assign m[2] = in_ch.in_r0_c2;
  assign m[3] = in_ch.in_r1_c0;
  assign m[4] = in_ch.in_r1_c1;
  assign m[5] = in_ch.in_r1_c2;
  assign m[6] = in_ch.in_r2_c0;
  assign m[7] = in_ch.in_r2_c1;
  assign m[8] = in_ch.in_r2_c2;

  // The pipeline moves whenever the output register is free or being read.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  mi3_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk     (clk),
    .en      (en),
    .m       (m),
    .adj_mag (adj_mag),
    .det_mag (det_mag),
    .ctl     (ctl)
  );

  // One divider lane per inverse element.
  for (genvar e = 0; e < N_ELEM; e++) begin : g_lane
    mi3_lane #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_lane (
      .clk     (clk),
      .en      (en),
      .num_mag (adj_mag[e]),
      .den_mag (det_mag),
      .ctl_in  (ctl[e]),
      .res     (lane_res[e]),
      .ctl_out (lane_ctl[e])
    );
  end

  // Valid bits that follow each word through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PL-2:0], in_ch.valid};
      out_valid_r <= vld_r[PL-1];
    end
  end

  // Merge the lanes into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      res_r      <= lane_res;
      singular_r <= lane_ctl[0].zero;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_r0_c0 = res_r[0];
  assign out_ch.out_r0_c1 = res_r[1];
  assign out_ch.out_r0_c2 = res_r[2];
  assign out_ch.out_r1_c0 = res_r[3];
  assign out_ch.out_r1_c1 = res_r[4];
  assign out_ch.out_r1_c2 = res_r[5];
  assign out_ch.out_r2_c0 = res_r[6];
  assign out_ch.out_r2_c1 = res_r[7];
  assign out_ch.out_r2_c2 = res_r[8];
  assign out_ch.singular  = singular_r;

endmodule
